>>> rtl/core/iirl_pkg.sv
package iirl_pkg;

	localparam int DEPTH = 16;
	localparam int ELEM_WIDTH = 32;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

	typedef logic [ELEM_WIDTH-1:0] elem_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CMP_W-1:0] cmp_t;

	typedef enum logic [2:0] {
		CMD_APPEND = 3'd0,
		CMD_INS_HEAD = 3'd1,
		CMD_INS_AFTER = 3'd2,
		CMD_REMOVE = 3'd3,
		CMD_READ = 3'd4,
		CMD_CLEAR = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [3:0] position;
		logic [31:0] item_value;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [31:0] read_value;
		logic [4:0] count;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic from_prev;
		logic from_next;
	} cell_ctl_t;

endpackage

>>> rtl/core/indexed_insert_remove_list_unit.sv
// channel | direction | payload          | handshake
// req     | in        | iirl_pkg::req_t  | req_valid, req_stall
// rsp     | out       | iirl_pkg::rsp_t  | rsp_valid, rsp_stall
//
// one request per cycle while req_stall is low; its response appears in the register the cycle after
// on insert or remove, all cells from the position onward update at once along the row of cells
// reset clears the count and the response valid flag; cell contents stay undefined
// req_stall is high only while a response waits and rsp_stall holds it
module indexed_insert_remove_list_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  iirl_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output iirl_pkg::rsp_t rsp
);

	iirl_pkg::cnt_t occupied_q;
	logic rsp_valid_q;
	iirl_pkg::rsp_t rsp_q;

	iirl_pkg::elem_t cell_value [iirl_pkg::DEPTH];
	iirl_pkg::cell_ctl_t cell_ctl [iirl_pkg::DEPTH];

	logic acc;
	logic do_ins;
	logic do_rem;
	iirl_pkg::cmp_t ins_at;
	iirl_pkg::cmp_t pos_c;
	iirl_pkg::cmp_t cnt_c;
	iirl_pkg::cnt_t cnt_nxt;
	iirl_pkg::status_t status;
	logic [31:0] rd;
	logic full;
	iirl_pkg::elem_t item;

	assign req_stall = rsp_valid_q & rsp_stall;
	assign acc = req_valid & ~req_stall;
	assign pos_c = iirl_pkg::CMP_W'(req.position);
	assign cnt_c = iirl_pkg::CMP_W'(occupied_q);
	assign full = (cnt_c >= iirl_pkg::CMP_W'(iirl_pkg::DEPTH));
	assign item = iirl_pkg::ELEM_WIDTH'(req.item_value);

	always_comb begin
		status = iirl_pkg::ST_OK;
		rd = '0;
		cnt_nxt = occupied_q;
		do_ins = 1'b0;
		do_rem = 1'b0;
		ins_at = '0;
		case (req.cmd)
			iirl_pkg::CMD_APPEND: begin
				if (full) begin
					status = iirl_pkg::ST_FULL;
				end else begin
					do_ins = 1'b1;
					ins_at = cnt_c;
					cnt_nxt = occupied_q + 1'b1;
				end
			end
			iirl_pkg::CMD_INS_HEAD: begin
				if (full) begin
					status = iirl_pkg::ST_FULL;
				end else begin
					do_ins = 1'b1;
					cnt_nxt = occupied_q + 1'b1;
				end
			end
			iirl_pkg::CMD_INS_AFTER: begin
				if (pos_c >= cnt_c) begin
					status = iirl_pkg::ST_RANGE;
				end else if (full) begin
					status = iirl_pkg::ST_FULL;
				end else begin
					do_ins = 1'b1;
					ins_at = pos_c + 1'b1;
					cnt_nxt = occupied_q + 1'b1;
				end
			end
			iirl_pkg::CMD_REMOVE: begin
				if (pos_c >= cnt_c) begin
					status = iirl_pkg::ST_RANGE;
				end else begin
					do_rem = 1'b1;
					cnt_nxt = occupied_q - 1'b1;
				end
			end
			iirl_pkg::CMD_READ: begin
				if (pos_c >= cnt_c) begin
					status = iirl_pkg::ST_RANGE;
				end else begin
					rd = 32'(cell_value[pos_c[iirl_pkg::IDX_W-1:0]]);
				end
			end
			iirl_pkg::CMD_CLEAR: begin
				cnt_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	for (genvar i = 0; i < iirl_pkg::DEPTH; i++) begin : g_cell
		localparam iirl_pkg::cmp_t IDX = iirl_pkg::CMP_W'(i);
		iirl_pkg::elem_t prev_v;
		iirl_pkg::elem_t next_v;

		if (i == 0) begin : g_first
			assign prev_v = item;
		end else begin : g_mid
			assign prev_v = cell_value[i-1];
		end
		if (i == iirl_pkg::DEPTH - 1) begin : g_last
			assign next_v = cell_value[i];
		end else begin : g_body
			assign next_v = cell_value[i+1];
		end

		assign cell_ctl[i].load = acc & do_ins & (IDX == ins_at);
		assign cell_ctl[i].from_prev = acc & do_ins & (IDX > ins_at);
		assign cell_ctl[i].from_next = acc & do_rem & (IDX >= pos_c);

		iirl_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl[i]),
			.item      (item),
			.prev_value(prev_v),
			.next_value(next_v),
			.value     (cell_value[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupied_q <= '0;
			rsp_valid_q <= 1'b0;
		end else if (acc) begin
			occupied_q <= cnt_nxt;
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rsp_q.status <= status;
			rsp_q.read_value <= rd;
			rsp_q.count <= 5'(cnt_nxt);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

>>> rtl/core/iirl_cell.sv
module iirl_cell (
	input  logic                clk,
	input  iirl_pkg::cell_ctl_t ctl,
	input  iirl_pkg::elem_t     item,
	input  iirl_pkg::elem_t     prev_value,
	input  iirl_pkg::elem_t     next_value,
	output iirl_pkg::elem_t     value
);

	iirl_pkg::elem_t value_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			value_q <= item;
		end else if (ctl.from_prev) begin
			value_q <= prev_value;
		end else if (ctl.from_next) begin
			value_q <= next_value;
		end
	end

	assign value = value_q;

endmodule
